### rtl/core/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared constants, Gaussian weight table and controller state encoding
// for the Harris corner response core.
// ----------------------------------------------------------------------------
package hcr_pkg;

  localparam int GAUSS_TAPS = 7;
  localparam int GAUSS_HALF = GAUSS_TAPS / 2;
  localparam int RING_LG    = 4;
  localparam int MIN_DIM    = 8;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_K      = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  function automatic logic [13:0] gauss_w(input logic [2:0] idx);
    logic [13:0] w;
    case (idx)
      3'd0: w = 14'd4598;
      3'd1: w = 14'd8590;
      3'd2: w = 14'd12499;
      3'd3: w = 14'd14162;
      3'd4: w = 14'd12499;
      3'd5: w = 14'd8590;
      3'd6: w = 14'd4598;
      default: w = 14'd0;
    endcase
    return w;
  endfunction

  function automatic logic [27:0] gauss_ww(input logic [2:0] i, input logic [2:0] j);
    logic [27:0] p;
    p = 28'(gauss_w(i)) * 28'(gauss_w(j));
    return p;
  endfunction

endpackage

### rtl/core/harris_corner_response_core.sv
// ----------------------------------------------------------------------------
// harris_corner_response_core
// Harris corner response over a raster stream of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Requests enter on the in_ stream: tuser 0 carries a gray pixel in tdata,
// tuser 1 is a flush that drains one pending result after the frame is in.
// Results leave on the out_ stream with the response, column and row in
// tdata and tlast on the final pixel of the frame. Registers are written on
// the cfg_ channel (width, height, k); geometry is latched at the first pixel
// of each frame. A pixel request that produces no result leaves the core idle.
// A request that produces a result scans the window for interior pixels
// (7x7 window of 3x3 Sobel reads, one gray-store read per cycle, bounded by
// its single read port), drains the pipeline and computes the response;
// pixels within 3 of an edge skip the scan. A result waits in the output register
// while the receiver stalls; the core takes the next request meanwhile and
// holds only when a new result is ready and the register is still full.
// Reset clears counters and the output register and restores 640 x 480, k
// 2621; the line store needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module harris_corner_response_core
  import hcr_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] gray_pixel
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [42:0] response, [52:43] out_col, [64:53] out_row
  output logic        out_tlast,  // last_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = RING_LG + CW;

  state_t state_r;
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [14:0] k_r;
  logic [CW:0] fw_r;
  logic [12:0] fh_r;
  logic [CW-1:0] in_col_r, out_col_r;
  logic [11:0] in_row_r, out_row_r;
  logic in_done_r;

  logic [7:0] gray_mem [0:(1<<AW)-1];
  logic [7:0] mem_q_r;
  logic [AW-1:0] rd_addr;

  logic [2:0] wi_r, wj_r;
  logic [1:0] dx_r, dy_r;

  logic m_valid_r, m_first_r, m_last_r;
  logic signed [2:0] m_kx_r, m_ky_r;
  logic [2:0] m_i_r, m_j_r;
  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [11:0] gx_acc_r, gy_acc_r, gx_r, gy_r;
  logic [27:0] ww_r, ww2_r;
  logic signed [23:0] pxx_r, pxy_r, pyy_r;
  logic signed [53:0] mxx_r, mxy_r, myy_r;
  logic signed [53:0] sa_r, sb_r, sc_r;

  logic [2:0] fstep_r;
  logic signed [21:0] a_r, b_r, c_r;
  logic signed [43:0] ac_r, bb_r;
  logic [21:0] tr_r;
  logic signed [44:0] det_r;
  logic [36:0] ktr_r;
  logic [47:0] plo_r, phi_r;

  logic out_tvalid_r, out_tlast_r;
  logic [71:0] out_tdata_r;

  logic in_acc, is_flush, first_px, in_last, emit_px, start_emit;
  logic [CW:0] fw_cur, fw_clamp;
  logic [12:0] fh_cur, fh_clamp;
  logic border;
  logic scan_last, sob_ok;
  logic signed [2:0] kx, ky;
  logic signed [11:0] tx, ty, gx_nxt, gy_nxt;
  logic signed [8:0] pix;
  logic signed [53:0] ra, rb, rc;
  logic [59:0] ksum;
  logic signed [45:0] resp;
  logic out_free, fin_done, out_last;
  logic [13:0] y0, x0;
  logic [11:0] ry;
  logic [CW:0] rx;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  always_comb begin
    if (width_r < 11'd8) fw_clamp = (CW+1)'(MIN_DIM);
    else if (32'(width_r) > MAX_WIDTH) fw_clamp = (CW+1)'(MAX_WIDTH);
    else fw_clamp = (CW+1)'(width_r);
    if (height_r < 13'd8) fh_clamp = 13'(MIN_DIM);
    else if (32'(height_r) > MAX_HEIGHT) fh_clamp = 13'(MAX_HEIGHT);
    else fh_clamp = height_r;
  end

  assign in_acc   = in_tvalid && in_tready;
  assign is_flush = (in_tuser == REQ_FLUSH);
  assign first_px = !in_done_r && (in_row_r == 12'd0) && (in_col_r == '0);
  assign fw_cur   = first_px ? fw_clamp : fw_r;
  assign fh_cur   = first_px ? fh_clamp : fh_r;
  assign in_last  = ((CW+1)'(in_col_r) + 1'b1 == fw_cur) && (13'(in_row_r) + 1'b1 == fh_cur);
  assign emit_px  = (in_row_r > 12'd4) || ((in_row_r == 12'd4) && (in_col_r >= CW'(4)));
  assign start_emit = in_acc && (is_flush ? in_done_r : (!in_done_r && emit_px));

  assign border = (out_row_r < 12'd3) || (out_col_r < CW'(3)) ||
                  (13'(out_row_r) + 13'd3 >= fh_r) ||
                  ((CW+1)'(out_col_r) + (CW+1)'(3) >= fw_r);

  // window scan address and coefficients
  always_comb begin
    y0 = 14'(out_row_r) + 14'(wi_r) - 14'd3;
    x0 = 14'(out_col_r) + 14'(wj_r) - 14'd3;
    sob_ok = (y0 != 14'd0) && (x0 != 14'd0) && (y0 + 14'd1 < 14'(fh_r)) &&
             (x0 + 14'd1 < 14'(fw_r));
    ry = out_row_r + 12'(wi_r) + 12'(dy_r) - 12'd4;
    rx = (CW+1)'(out_col_r) + (CW+1)'(wj_r) + (CW+1)'(dx_r) - (CW+1)'(4);
    rd_addr = {ry[RING_LG-1:0], rx[CW-1:0]};
    kx = (3'sd1 * $signed({1'b0, dx_r}) - 3'sd1) * ((dy_r == 2'd1) ? 3'sd2 : 3'sd1);
    ky = ((dx_r == 2'd1) ? 3'sd2 : 3'sd1) * ($signed({1'b0, dy_r}) - 3'sd1);
    scan_last = (dx_r == 2'd2) && (dy_r == 2'd2) && (wj_r == 3'd6) && (wi_r == 3'd6);
  end

  always_comb begin
    pix = $signed({1'b0, mem_q_r});
    tx = m_valid_r ? 12'(m_kx_r * pix) : 12'sd0;
    ty = m_valid_r ? 12'(m_ky_r * pix) : 12'sd0;
    gx_nxt = (m_first_r ? 12'sd0 : gx_acc_r) + tx;
    gy_nxt = (m_first_r ? 12'sd0 : gy_acc_r) + ty;
  end

  always_comb begin
    ra = sa_r + 54'sd2147483648;
    rb = sb_r + 54'sd2147483648;
    rc = sc_r + 54'sd2147483648;
    ksum = {12'd0, plo_r} + {1'b0, phi_r, 11'd0} + 60'd32768;
    resp = 46'(det_r) - $signed({2'b00, ksum[59:16]});
    out_free = !out_tvalid_r || out_tready;
    fin_done = (state_r == ST_FIN) && (fstep_r == 3'd4) && out_free;
    out_last = ((CW+1)'(out_col_r) + 1'b1 == fw_r) && (13'(out_row_r) + 1'b1 == fh_r);
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_flush && !in_done_r) begin
      gray_mem[{in_row_r[RING_LG-1:0], in_col_r}] <= in_tdata;
    end
    mem_q_r <= gray_mem[rd_addr];
  end

  // datapath: sobel accumulate, products, weighting, window sums and response terms
  always_ff @(posedge clk) begin
    m_valid_r <= sob_ok;
    m_kx_r    <= kx;
    m_ky_r    <= ky;
    m_first_r <= (dx_r == 2'd0) && (dy_r == 2'd0);
    m_last_r  <= (dx_r == 2'd2) && (dy_r == 2'd2);
    m_i_r     <= wi_r;
    m_j_r     <= wj_r;
    if (v1_r) begin
      gx_acc_r <= gx_nxt;
      gy_acc_r <= gy_nxt;
      if (m_last_r) begin
        gx_r <= gx_nxt;
        gy_r <= gy_nxt;
        ww_r <= gauss_ww(m_i_r, m_j_r);
      end
    end
    pxx_r <= gx_r * gx_r;
    pxy_r <= gx_r * gy_r;
    pyy_r <= gy_r * gy_r;
    ww2_r <= ww_r;
    mxx_r <= $signed({1'b0, ww2_r}) * pxx_r;
    mxy_r <= $signed({1'b0, ww2_r}) * pxy_r;
    myy_r <= $signed({1'b0, ww2_r}) * pyy_r;
    if (start_emit) begin
      sa_r <= '0;
      sb_r <= '0;
      sc_r <= '0;
    end else if (v4_r) begin
      sa_r <= sa_r + mxx_r;
      sb_r <= sb_r + mxy_r;
      sc_r <= sc_r + myy_r;
    end
    a_r   <= ra[53:32];
    b_r   <= rb[53:32];
    c_r   <= rc[53:32];
    ac_r  <= a_r * c_r;
    bb_r  <= b_r * b_r;
    tr_r  <= 22'($unsigned(a_r) + $unsigned(c_r));
    det_r <= 45'(ac_r) - 45'(bb_r);
    ktr_r <= 37'(k_r) * 37'(tr_r);
    plo_r <= 48'(ktr_r) * 48'(tr_r[10:0]);
    phi_r <= 48'(ktr_r) * 48'(tr_r[21:11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      width_r      <= 11'd640;
      height_r     <= 13'd480;
      k_r          <= 15'd2621;
      fw_r         <= (CW+1)'(640);
      fh_r         <= 13'd480;
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      in_done_r    <= 1'b0;
      wi_r         <= '0;
      wj_r         <= '0;
      dx_r         <= '0;
      dy_r         <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      fstep_r      <= '0;
      out_tvalid_r <= 1'b0;
      out_tlast_r  <= 1'b0;
      out_tdata_r  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_data[10:0];
          REG_HEIGHT: height_r <= cfg_data[12:0];
          REG_K:      k_r      <= cfg_data;
          default: ;
        endcase
      end
      v1_r <= (state_r == ST_SCAN);
      v2_r <= v1_r && m_last_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (out_tvalid_r && out_tready && !fin_done) out_tvalid_r <= 1'b0;

      // advance input raster
      if (in_acc && !is_flush && !in_done_r) begin
        if (first_px) begin
          fw_r <= fw_clamp;
          fh_r <= fh_clamp;
        end
        if (in_last) begin
          in_done_r <= 1'b1;
        end else if ((CW+1)'(in_col_r) + 1'b1 == fw_cur) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 12'd1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end

      case (state_r)
        ST_IDLE: begin
          if (start_emit) begin
            wi_r <= '0;
            wj_r <= '0;
            dx_r <= '0;
            dy_r <= '0;
            fstep_r <= '0;
            state_r <= border ? ST_FIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state_r <= ST_DRAIN;
          end
          if (dx_r != 2'd2) begin
            dx_r <= dx_r + 2'd1;
          end else begin
            dx_r <= '0;
            if (dy_r != 2'd2) begin
              dy_r <= dy_r + 2'd1;
            end else begin
              dy_r <= '0;
              if (wj_r != 3'd6) begin
                wj_r <= wj_r + 3'd1;
              end else begin
                wj_r <= '0;
                wi_r <= wi_r + 3'd1;
              end
            end
          end
        end
        ST_DRAIN: begin
          if (!v1_r && !v2_r && !v3_r && !v4_r) begin
            fstep_r <= '0;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fstep_r != 3'd4) begin
            fstep_r <= fstep_r + 3'd1;
          end else if (fin_done) begin
            out_tvalid_r <= 1'b1;
            out_tlast_r  <= out_last;
            out_tdata_r  <= {7'd0, 12'(out_row_r), 10'(out_col_r), resp[42:0]};
            state_r      <= ST_IDLE;
            if (out_last) begin
              out_col_r <= '0;
              out_row_r <= '0;
              in_col_r  <= '0;
              in_row_r  <= '0;
              in_done_r <= 1'b0;
            end else if ((CW+1)'(out_col_r) + 1'b1 == fw_r) begin
              out_col_r <= '0;
              out_row_r <= out_row_r + 12'd1;
            end else begin
              out_col_r <= out_col_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/tb_harris_corner_response_core.sv
// ----------------------------------------------------------------------------
// tb_harris_corner_response_core
// Self-checking bench for the Harris corner response core. Small frames of
// gray pixels go in on the request stream with bursty timing, and flush
// requests drain each frame. A behavioral model of the Sobel, Gaussian and
// response datapath predicts every result. The result stream stalls on its
// own pattern and is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_harris_corner_response_core
  import hcr_pkg::*;
;

  localparam int         MAXW      = 1024;
  localparam int         RING      = 32;
  localparam int         LIMIT     = 3000000;
  localparam int         SETTLE    = 600;
  localparam logic [1:0] REG_NONE  = 2'd3;

  typedef struct {
    logic [42:0] response;
    logic [9:0]  col;
    logic [11:0] row;
    logic        last;
  } harris_res_t;

  typedef struct {
    logic       kind;
    logic [7:0] pixel;
    logic       no_res;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] gray_pixel
  logic        in_tuser = 1'b0; // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // [42:0] response, [52:43] out_col, [64:53] out_row
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  harris_corner_response_core #(.MAX_WIDTH(MAXW)) u_dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [7:0]  gray_ring [RING*MAXW];
  int unsigned img_w, img_h, k_q16, frm_w, frm_h, pix_pos, res_pos;
  harris_res_t expected_q[$];

  int          errors = 0;
  int          items = 0;
  longint      cycles = 0;
  int          burst_left = 0;
  int          hold_cnt = 0;
  bit          hold_req = 0;
  logic [15:0] stall_mask = 16'hFFFF;

  const longint unsigned GW[7] = '{4598, 8590, 12499, 14162, 12499, 8590, 4598};

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic longint gray_at(int unsigned y, int unsigned x);
    return longint'(gray_ring[(y % RING) * MAXW + (x % MAXW)]);
  endfunction

  function automatic void grad_at(int unsigned y, int unsigned x,
                                  output longint gx, output longint gy);
    gx = 0;
    gy = 0;
    if (y == 0 || x == 0 || y + 1 >= frm_h || x + 1 >= frm_w) return;
    gx = (gray_at(y-1, x+1) - gray_at(y-1, x-1)) + 2 * (gray_at(y, x+1) - gray_at(y, x-1))
       + (gray_at(y+1, x+1) - gray_at(y+1, x-1));
    gy = (gray_at(y+1, x-1) + 2 * gray_at(y+1, x) + gray_at(y+1, x+1))
       - (gray_at(y-1, x-1) + 2 * gray_at(y-1, x) + gray_at(y-1, x+1));
  endfunction

  function automatic longint round32(longint v);
    return (v + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic longint response_at(int unsigned r, int unsigned c);
    longint sa, sb, sc, ha, hb, hc, gx, gy, a, b, cc, tr, kt;
    sa = 0; sb = 0; sc = 0;
    if (r < 3 || c < 3 || r + 3 >= frm_h || c + 3 >= frm_w) return 0;
    for (int i = 0; i < 7; i++) begin
      ha = 0; hb = 0; hc = 0;
      for (int j = 0; j < 7; j++) begin
        grad_at(r - 3 + i, c - 3 + j, gx, gy);
        ha += longint'(GW[j]) * (gx * gx);
        hb += longint'(GW[j]) * (gx * gy);
        hc += longint'(GW[j]) * (gy * gy);
      end
      sa += longint'(GW[i]) * ha;
      sb += longint'(GW[i]) * hb;
      sc += longint'(GW[i]) * hc;
    end
    a = round32(sa);
    b = round32(sb);
    cc = round32(sc);
    tr = a + cc;
    kt = (longint'(k_q16) * (tr * tr) + 32768) >>> 16;
    return (a * cc - b * b) - kt;
  endfunction

  function automatic void emit_result();
    harris_res_t e;
    int unsigned r, c;
    r = res_pos / frm_w;
    c = res_pos % frm_w;
    e.response = 43'(response_at(r, c));
    e.col = 10'(c);
    e.row = 12'(r);
    e.last = (res_pos + 1 == frm_w * frm_h);
    expected_q = {expected_q, e};
    res_pos++;
    if (res_pos >= frm_w * frm_h) begin
      pix_pos = 0;
      res_pos = 0;
    end
  endfunction

  function automatic void predict_request(logic kind, logic [7:0] pixel);
    int unsigned n;
    if (kind == REQ_FLUSH) begin
      if (pix_pos == frm_w * frm_h && res_pos < frm_w * frm_h) emit_result();
      return;
    end
    if (pix_pos == 0) begin
      frm_w = img_w < 8 ? 8 : (img_w > MAXW ? MAXW : img_w);
      frm_h = img_h < 8 ? 8 : (img_h > 4096 ? 4096 : img_h);
    end
    if (pix_pos >= frm_w * frm_h) return;
    n = pix_pos;
    gray_ring[((n / frm_w) % RING) * MAXW + (n % frm_w)] = pixel;
    pix_pos = n + 1;
    if (n >= 4 * (frm_w + 1)) emit_result();
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH:  img_w = val[10:0];
      REG_HEIGHT: img_h = val[12:0];
      REG_K:      k_q16 = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_request(logic kind, logic [7:0] pixel);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= pixel;
    do @(posedge clk); while (!in_tready);
    predict_request(kind, pixel);
    items++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    wait (expected_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] make_pixel(int mode);
    int unsigned x, y;
    x = pix_pos % frm_w;
    y = pix_pos / frm_w;
    case (mode)
      0: return 8'($urandom);
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return (((x / 3) + (y / 3)) & 1) ? 8'hFF : 8'($urandom_range(0, 15));
    endcase
  endfunction

  // finish the current frame: pixels, then flushes, with occasional noise
  task automatic finish_frame(int mode, bit long_hold, bit pause);
    while (pix_pos < frm_w * frm_h || pix_pos == 0) begin
      if ($urandom_range(0, 19) == 0 && pix_pos != 0) send_request(REQ_FLUSH, 8'($urandom));
      else send_request(REQ_PIXEL, make_pixel(mode));
      if (long_hold && res_pos == 2) begin
        hold_req = 1;
        long_hold = 0;
      end
      if (pause && res_pos == 3) begin
        in_tvalid <= 1'b0;
        burst_left = 0;
        wait (expected_q.size() == 0);
        @(posedge clk);
        pause = 0;
      end
    end
    while (pix_pos != 0) begin
      if ($urandom_range(0, 19) == 0) send_request(REQ_PIXEL, 8'($urandom));
      else send_request(REQ_FLUSH, 8'($urandom));
    end
    if ($urandom_range(0, 1)) send_request(REQ_FLUSH, 8'($urandom));
  endtask

  req_row_t directed[$] = '{
    '{REQ_FLUSH, 8'h00, 1'b1}, '{REQ_FLUSH, 8'hFF, 1'b1},
    '{REQ_PIXEL, 8'h00, 1'b1}, '{REQ_PIXEL, 8'hFF, 1'b1}, '{REQ_PIXEL, 8'h00, 1'b1},
    '{REQ_PIXEL, 8'hFF, 1'b1}, '{REQ_FLUSH, 8'h00, 1'b1}, '{REQ_PIXEL, 8'hAA, 1'b1},
    '{REQ_PIXEL, 8'h55, 1'b1}, '{REQ_PIXEL, 8'h01, 1'b1}, '{REQ_PIXEL, 8'h80, 1'b1},
    '{REQ_PIXEL, 8'hFE, 1'b1}, '{REQ_PIXEL, 8'h7F, 1'b1}, '{REQ_PIXEL, 8'hFF, 1'b1},
    '{REQ_PIXEL, 8'hFF, 1'b1}, '{REQ_PIXEL, 8'h00, 1'b1}, '{REQ_PIXEL, 8'h00, 1'b1},
    '{REQ_PIXEL, 8'hFF, 1'b1}, '{REQ_PIXEL, 8'h00, 1'b1}, '{REQ_PIXEL, 8'hFF, 1'b1}
  };

  // result checker and stall pattern
  always @(posedge clk) begin
    harris_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", out_tdata[42:0], 0);
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[42:0] !== e.response) report("response", out_tdata[42:0], e.response);
        if (out_tdata[52:43] !== e.col) report("col", out_tdata[52:43], e.col);
        if (out_tdata[64:53] !== e.row) report("row", out_tdata[64:53], e.row);
        if (out_tdata[71:65] !== '0) report("pad", out_tdata[71:65], 0);
        if (out_tlast !== e.last) report("last", out_tlast, e.last);
      end
    end
    if (hold_req) begin
      hold_cnt = 5000;
      hold_req = 0;
    end
    if (cycles % 16 == 0)
      stall_mask = $urandom_range(0, 2) == 0 ? 16'hFFFF : 16'($urandom | $urandom);
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= stall_mask[cycles % 16];
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_harris_corner_response_core: FAIL");
      $finish;
    end
  end

  initial begin
    int fr;
    int unsigned w, h;
    img_w = 640; img_h = 480; k_q16 = 2621;
    frm_w = 640; frm_h = 480; pix_pos = 0; res_pos = 0;
    foreach (gray_ring[i]) gray_ring[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_WIDTH, 15'd2047);
    write_reg(REG_HEIGHT, 15'd8191);
    write_reg(REG_NONE, 15'h7FFF);
    write_reg(REG_WIDTH, 15'd8);
    write_reg(REG_HEIGHT, 15'd8);
    write_reg(REG_K, 15'd0);
    foreach (directed[i]) begin
      fr = expected_q.size();
      send_request(directed[i].kind, directed[i].pixel);
      if (directed[i].no_res && expected_q.size() != fr) report("directed row", i, 0);
    end
    finish_frame(1, 0, 0);
    settle();

    fr = 0;
    while (items < 900) begin
      w = $urandom_range(0, 5) == 0 ? $urandom_range(0, 7) : $urandom_range(8, 14);
      h = $urandom_range(0, 5) == 0 ? $urandom_range(0, 7) : $urandom_range(8, 13);
      write_reg(REG_WIDTH, 15'(w));
      write_reg(REG_HEIGHT, 15'(h));
      case ($urandom_range(0, 5))
        0: write_reg(REG_K, 15'd0);
        1: write_reg(REG_K, 15'd16384);
        2: write_reg(REG_K, 15'h7FFF);
        default: write_reg(REG_K, 15'($urandom_range(0, 16384)));
      endcase
      finish_frame($urandom_range(0, 2), fr == 1, fr == 2);
      settle();
      fr++;
    end

    settle();
    if (errors == 0) begin
      $display("tb_harris_corner_response_core: PASS");
    end else begin
      $display("tb_harris_corner_response_core: FAIL");
    end
    $finish;
  end

endmodule
